// ===== rtl/core/tts_pkg.sv =====
// Shared types and constants for the tick task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  // Task slots, the width of a slot number and the width of a counter
  localparam int TASK_COUNT = 8;
  localparam int IDX_W      = 3;
  localparam int CNT_W      = 16;

  // Command codes carried by an input transaction
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_DISPATCH = 2'd2
  } cmd_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK_WALK,
    ST_DISP_WALK,
    ST_DISP_EMPTY
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic add_en;      // program the slot named by the input transaction
    logic slot_load;   // start a walk at the highest slot
    logic slot_dec;    // advance the walk to the next lower slot
    logic tick_upd;    // count down the current slot
    logic disp_take;   // report the current slot and clear its flag
    logic empty_emit;  // report that nothing was ready
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic any_pending;   // some task is ready
    logic slot_pending;  // current slot is ready
    logic slot_last;     // no ready task below the current slot
    logic slot_zero;     // walk is at the lowest slot
    logic out_free;      // output register can take a result this cycle
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tick_task_scheduler.sv =====
// Top level of the tick task scheduler: controller plus task datapath.
// Add: written while idle; the next transaction can follow in the next cycle.
// Tick: the walker visits one task slot per cycle; input stalls until it passes slot 0.
// Dispatch: decoded while idle, then one slot per cycle (up to 8), but a ready slot
//   waits while the output register is busy; each take is reported the cycle after.
// Synchronous active-low reset clears all counters, intervals and ready flags at once.
`timescale 1ns / 1ps
`default_nettype none

module tick_task_scheduler (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_cmd,
  input  wire logic [tts_pkg::IDX_W-1:0] in_task_index,
  input  wire logic [tts_pkg::CNT_W-1:0] in_start_count,
  input  wire logic [tts_pkg::CNT_W-1:0] in_reload_interval,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [tts_pkg::IDX_W-1:0]      out_ready_task,
  output logic                           out_is_ready,
  output logic                           out_last
);

  tts_pkg::ctl_t  ctl;
  tts_pkg::stat_t stat;

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  tts_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .stat               (stat),
    .in_task_index      (in_task_index),
    .in_start_count     (in_start_count),
    .in_reload_interval (in_reload_interval),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_ready_task     (out_ready_task),
    .out_is_ready       (out_is_ready),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tts_datapath.sv =====
// Task counters, reload intervals, ready flags, slot walker and output register.
`timescale 1ns / 1ps
`default_nettype none

module tts_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tts_pkg::ctl_t                ctl,
  output tts_pkg::stat_t                    stat,
  input  wire logic [tts_pkg::IDX_W-1:0]    in_task_index,
  input  wire logic [tts_pkg::CNT_W-1:0]    in_start_count,
  input  wire logic [tts_pkg::CNT_W-1:0]    in_reload_interval,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic [tts_pkg::IDX_W-1:0]         out_ready_task,
  output logic                              out_is_ready,
  output logic                              out_last
);

  logic [tts_pkg::CNT_W-1:0]      countdown_r [tts_pkg::TASK_COUNT];
  logic [tts_pkg::CNT_W-1:0]      interval_r  [tts_pkg::TASK_COUNT];
  logic [tts_pkg::TASK_COUNT-1:0] pending_r;
  logic [tts_pkg::IDX_W-1:0]      slot_r;
  logic [tts_pkg::IDX_W-1:0]      slot_nxt;
  logic                           out_valid_r;
  logic [tts_pkg::IDX_W-1:0]      out_task_r;
  logic                           out_ready_r;
  logic                           out_last_r;
  logic [tts_pkg::CNT_W-1:0]      cur_cnt;
  logic [tts_pkg::CNT_W-1:0]      cur_dec;
  logic                           lower_pending;
  logic                           add_hit;

  // Walk position
  always_comb begin
    slot_nxt = slot_r;
    if (ctl.slot_load) begin
      slot_nxt = tts_pkg::IDX_W'(tts_pkg::TASK_COUNT - 1);
    end else if (ctl.slot_dec) begin
      slot_nxt = slot_r - tts_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  // Current slot countdown and ready flags below the walk position
  assign cur_cnt = countdown_r[slot_r];
  assign cur_dec = cur_cnt - tts_pkg::CNT_W'(1);
  assign add_hit = ctl.add_en && (int'(in_task_index) < tts_pkg::TASK_COUNT);

  always_comb begin
    lower_pending = 1'b0;
    for (int i = 0; i < tts_pkg::TASK_COUNT; i++) begin
      if (pending_r[i] && (tts_pkg::IDX_W'(i) < slot_r)) begin
        lower_pending = 1'b1;
      end
    end
  end

  // Task table: add writes one slot, tick and dispatch touch the walked slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tts_pkg::TASK_COUNT; i++) begin
        countdown_r[i] <= '0;
        interval_r[i]  <= '0;
      end
      pending_r <= '0;
    end else begin
      if (add_hit) begin
        countdown_r[in_task_index] <= in_start_count;
        interval_r[in_task_index]  <= in_reload_interval;
        pending_r[in_task_index]   <= 1'b0;
      end
      if (ctl.tick_upd && (cur_cnt != '0)) begin
        if (cur_dec == '0) begin
          countdown_r[slot_r] <= interval_r[slot_r];
          pending_r[slot_r]   <= 1'b1;
        end else begin
          countdown_r[slot_r] <= cur_dec;
        end
      end
      if (ctl.disp_take) begin
        pending_r[slot_r] <= 1'b0;
      end
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.disp_take || ctl.empty_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.disp_take) begin
      out_task_r  <= slot_r;
      out_ready_r <= 1'b1;
      out_last_r  <= !lower_pending;
    end else if (ctl.empty_emit) begin
      out_task_r  <= '0;
      out_ready_r <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  // Status to the controller
  assign stat.any_pending  = |pending_r;
  assign stat.slot_pending = pending_r[slot_r];
  assign stat.slot_last    = !lower_pending;
  assign stat.slot_zero    = (slot_r == '0);
  assign stat.out_free     = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_ready_task = out_task_r;
  assign out_is_ready   = out_ready_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/tts_ctrl.sv =====
// Controller state machine: decodes commands and sequences slot walks.
`timescale 1ns / 1ps
`default_nettype none

module tts_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_cmd,
  output logic                      in_stall,
  input  wire tts_pkg::stat_t       stat,
  output tts_pkg::ctl_t             ctl
);

  tts_pkg::state_t state_r;
  tts_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tts_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            tts_pkg::CMD_TICK:     state_nxt = tts_pkg::ST_TICK_WALK;
            tts_pkg::CMD_DISPATCH: begin
              state_nxt = stat.any_pending ? tts_pkg::ST_DISP_WALK
                                           : tts_pkg::ST_DISP_EMPTY;
            end
            default:               state_nxt = tts_pkg::ST_IDLE;
          endcase
        end
      end
      tts_pkg::ST_TICK_WALK: begin
        if (stat.slot_zero) begin
          state_nxt = tts_pkg::ST_IDLE;
        end
      end
      tts_pkg::ST_DISP_WALK: begin
        if (stat.slot_pending && stat.out_free && stat.slot_last) begin
          state_nxt = tts_pkg::ST_IDLE;
        end
      end
      tts_pkg::ST_DISP_EMPTY: begin
        if (stat.out_free) begin
          state_nxt = tts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tts_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      tts_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_cmd)
            tts_pkg::CMD_TICK:     ctl.slot_load = 1'b1;
            tts_pkg::CMD_ADD:      ctl.add_en    = 1'b1;
            tts_pkg::CMD_DISPATCH: ctl.slot_load = 1'b1;
            default:               ctl           = '0;
          endcase
        end
      end
      tts_pkg::ST_TICK_WALK: begin
        ctl.tick_upd = 1'b1;
        ctl.slot_dec = 1'b1;
      end
      tts_pkg::ST_DISP_WALK: begin
        if (stat.slot_pending) begin
          if (stat.out_free) begin
            ctl.disp_take = 1'b1;
            ctl.slot_dec  = 1'b1;
          end
        end else begin
          ctl.slot_dec = 1'b1;
        end
      end
      tts_pkg::ST_DISP_EMPTY: begin
        ctl.empty_emit = stat.out_free;
      end
      default: ctl = '0;
    endcase
  end

  // A dispatch walk always has a ready task at or below its position
  a_walk_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tts_pkg::ST_DISP_WALK) |-> stat.any_pending)
    else $error("dispatch walk with no ready task");

  // Results are only loaded into a free output register
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.disp_take || ctl.empty_emit) |-> stat.out_free)
    else $error("result loaded over an unaccepted result");

  // Only ready slots are reported
  a_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.disp_take |-> stat.slot_pending)
    else $error("reported a slot that is not ready");

  // A tick walk ends after the lowest slot
  a_tick_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tts_pkg::ST_TICK_WALK && stat.slot_zero) |=> (state_r == tts_pkg::ST_IDLE))
    else $error("tick walk did not end at the lowest slot");

endmodule

`default_nettype wire

// ===== sim/tb_tick_task_scheduler.sv =====
// Testbench for the tick task scheduler: directed and random command streams against a scoreboard.
`timescale 1ns / 1ps

module tb_tick_task_scheduler;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 45;

  // One dispatch report as it leaves the block
  typedef struct packed {
    logic [tts_pkg::IDX_W-1:0] task_id;
    logic                      is_ready;
    logic                      is_last;
  } report_t;

  logic                      clk                = 1'b0;
  logic                      rst_n              = 1'b0;
  logic                      in_valid           = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_cmd             = tts_pkg::CMD_TICK;
  logic [tts_pkg::IDX_W-1:0] in_task_index      = '0;
  logic [tts_pkg::CNT_W-1:0] in_start_count     = '0;
  logic [tts_pkg::CNT_W-1:0] in_reload_interval = '0;
  logic                      out_valid;
  logic                      out_stall          = 1'b0;
  logic [tts_pkg::IDX_W-1:0] out_ready_task;
  logic                      out_is_ready;
  logic                      out_last;

  // Scheduler shadow state and the reports still owed by the block
  logic [tts_pkg::CNT_W-1:0] slot_count  [tts_pkg::TASK_COUNT];
  logic [tts_pkg::CNT_W-1:0] slot_reload [tts_pkg::TASK_COUNT];
  logic                      slot_ready  [tts_pkg::TASK_COUNT];
  report_t                   due_reports [$];

  int send_idle_pct = 15;
  int recv_idle_pct = 57;
  int fail_count    = 0;
  int cycle_count   = 0;

  tick_task_scheduler uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_task_index      (in_task_index),
    .in_start_count     (in_start_count),
    .in_reload_interval (in_reload_interval),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ready_task     (out_ready_task),
    .out_is_ready       (out_is_ready),
    .out_last           (out_last)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clear the shadow scheduler to its reset state
  function automatic void clear_schedule();
    for (int i = 0; i < tts_pkg::TASK_COUNT; i++) begin
      slot_count[i]  = '0;
      slot_reload[i] = '0;
      slot_ready[i]  = 1'b0;
    end
  endfunction

  // Apply one accepted transaction to the shadow scheduler and queue its reports
  function automatic void advance_schedule(logic [1:0] cmd,
                                           logic [tts_pkg::IDX_W-1:0] idx,
                                           logic [tts_pkg::CNT_W-1:0] start,
                                           logic [tts_pkg::CNT_W-1:0] reload);
    report_t rpt;
    int      lowest;
    lowest = -1;
    case (cmd)
      tts_pkg::CMD_TICK: begin
        for (int i = tts_pkg::TASK_COUNT - 1; i >= 0; i--) begin
          if (slot_count[i] != '0) begin
            slot_count[i] = slot_count[i] - tts_pkg::CNT_W'(1);
            if (slot_count[i] == '0) begin
              slot_count[i] = slot_reload[i];
              slot_ready[i] = 1'b1;
            end
          end
        end
      end
      tts_pkg::CMD_ADD: begin
        if (int'(idx) < tts_pkg::TASK_COUNT) begin
          slot_count[idx]  = start;
          slot_reload[idx] = reload;
          slot_ready[idx]  = 1'b0;
        end
      end
      tts_pkg::CMD_DISPATCH: begin
        for (int i = tts_pkg::TASK_COUNT - 1; i >= 0; i--) begin
          if (slot_ready[i]) lowest = i;
        end
        if (lowest < 0) begin
          rpt = '{task_id: '0, is_ready: 1'b0, is_last: 1'b1};
          due_reports.push_back(rpt);
        end else begin
          for (int i = tts_pkg::TASK_COUNT - 1; i >= 0; i--) begin
            if (slot_ready[i]) begin
              rpt = '{task_id: tts_pkg::IDX_W'(i), is_ready: 1'b1, is_last: (i == lowest)};
              due_reports.push_back(rpt);
              slot_ready[i] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Drive one transaction, hold it until accepted, then update the shadow state
  task automatic send_item(input logic [1:0] cmd, input logic [tts_pkg::IDX_W-1:0] idx,
                           input logic [tts_pkg::CNT_W-1:0] start,
                           input logic [tts_pkg::CNT_W-1:0] reload);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_cmd             <= cmd;
    in_task_index      <= idx;
    in_start_count     <= start;
    in_reload_interval <= reload;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_schedule(cmd, idx, start, reload);
  endtask

  // Hold off until every owed report is out and the slot walker has settled
  task automatic await_idle();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_dispatch();
    send_item(tts_pkg::CMD_DISPATCH, '0, '0, '0);
  endtask

  // Zero reload: the task fires once, then stays disabled
  task automatic test_single_shot();
    send_item(tts_pkg::CMD_ADD, 3'd0, 16'd1, 16'd0);
    send_item(tts_pkg::CMD_TICK, '0, '0, '0);
    send_item(tts_pkg::CMD_DISPATCH, '0, '0, '0);
    send_item(tts_pkg::CMD_TICK, '0, '0, '0);
    send_item(tts_pkg::CMD_DISPATCH, '0, '0, '0);
  endtask

  // Every slot ready at once: reports run from the highest slot down
  task automatic test_full_house();
    for (int i = 0; i < tts_pkg::TASK_COUNT; i++) begin
      send_item(tts_pkg::CMD_ADD, tts_pkg::IDX_W'(i), 16'd1, tts_pkg::CNT_W'(i));
    end
    send_item(tts_pkg::CMD_TICK, '0, '0, '0);
    send_item(tts_pkg::CMD_DISPATCH, '1, '1, '1);
  endtask

  // Largest counts, a zero start that leaves the slot disabled
  task automatic test_count_extremes();
    send_item(tts_pkg::CMD_ADD, 3'd7, 16'hFFFF, 16'hFFFF);
    send_item(tts_pkg::CMD_ADD, 3'd5, 16'd0, 16'hFFFF);
    send_item(tts_pkg::CMD_ADD, 3'd2, 16'd1, 16'd1);
    send_item(tts_pkg::CMD_TICK, '0, '1, '1);
    send_item(tts_pkg::CMD_DISPATCH, '0, '0, '0);
  endtask

  // Re-adding a ready task drops its ready flag
  task automatic test_add_clears_ready();
    send_item(tts_pkg::CMD_ADD, 3'd3, 16'd1, 16'd3);
    send_item(tts_pkg::CMD_TICK, '0, '0, '0);
    send_item(tts_pkg::CMD_ADD, 3'd3, 16'd2, 16'd3);
    send_item(tts_pkg::CMD_DISPATCH, '0, '0, '0);
  endtask

  // The spare command code changes nothing
  task automatic test_unused_cmd();
    send_item(CMD_UNUSED, '1, '1, '1);
    send_item(tts_pkg::CMD_DISPATCH, '0, '0, '0);
  endtask

  // Mostly short-period tasks so ticks expire them often; some full-range values
  task automatic test_random_traffic(input int count);
    int                        pick;
    logic [tts_pkg::IDX_W-1:0] idx;
    logic [tts_pkg::CNT_W-1:0] start;
    logic [tts_pkg::CNT_W-1:0] reload;
    for (int k = 0; k < count; k++) begin
      pick   = $urandom_range(99);
      idx    = tts_pkg::IDX_W'($urandom);
      start  = tts_pkg::CNT_W'($urandom);
      reload = tts_pkg::CNT_W'($urandom);
      if (pick < 45) begin
        send_item(tts_pkg::CMD_TICK, idx, start, reload);
      end else if (pick < 72) begin
        if ($urandom_range(9) != 0) begin
          start  = tts_pkg::CNT_W'($urandom_range(4));
          reload = tts_pkg::CNT_W'($urandom_range(5));
        end
        send_item(tts_pkg::CMD_ADD, idx, start, reload);
      end else if (pick < 96) begin
        send_item(tts_pkg::CMD_DISPATCH, idx, start, reload);
      end else begin
        send_item(CMD_UNUSED, idx, start, reload);
      end
    end
  endtask

  // Random receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Compare each accepted report with the oldest one owed
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        $error("unexpected report: ready_task %0d is_ready %0b last %0b",
               out_ready_task, out_is_ready, out_last);
        fail_count++;
      end else begin
        want = due_reports.pop_front();
        if (out_ready_task !== want.task_id) begin
          $error("ready_task: expected %0d, got %0d", want.task_id, out_ready_task);
          fail_count++;
        end
        if (out_is_ready !== want.is_ready) begin
          $error("is_ready: expected %0b, got %0b", want.is_ready, out_is_ready);
          fail_count++;
        end
        if (out_last !== want.is_last) begin
          $error("last: expected %0b, got %0b", want.is_last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_schedule();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_dispatch();
    test_single_shot();
    test_full_house();
    test_count_extremes();
    test_add_clears_ready();
    test_unused_cmd();
    await_idle();

    test_random_traffic(RANDOM_ITEMS);
    await_idle();

    send_idle_pct = 57;
    recv_idle_pct = 15;
    test_random_traffic(RANDOM_ITEMS);
    await_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS);
    await_idle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
